/* hdl/prr_pkg.sv */
// Shared types and constants for the priority refcount registry.
// Entry layout, result bundle, request and status codes.
// No dependencies.
package prr_pkg;

  // Default number of table slots
  localparam int unsigned TableDepthDef = 16;

  // Saturation value of a reference count
  localparam logic [15:0] RefsMax = 16'hFFFF;

  // Request codes
  localparam logic ReqAdd    = 1'b0;
  localparam logic ReqRemove = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // One table entry as stored in memory
  typedef struct packed {
    logic [31:0] handler;
    logic [15:0] prio;
    logic [15:0] refs;
    logic        notify;
  } entry_t;

  // Finished result handed from the sequencer to the output stage
  typedef struct packed {
    logic       valid;
    status_e    status;
    logic [4:0] used;
  } res_t;

endpackage

/* hdl/priority_refcount_registry.sv */
// Top level of the priority refcount registry.
// Holds the result register; uses prr_ctrl, prr_mem and prr_pkg.
//
// Usage:
//   Requests come in on in_valid_i / in_stall_o with req_type_i (add or
//   remove), handler_id_i, priority_req_i and always_notify_i. A request is
//   taken at a clock edge with in_valid_i high and in_stall_o low.
//   Each request gives exactly one result on out_valid_o / out_stall_i:
//   status_o (ok, not found, table full) and entries_used_o.
// Operation:
//   One request is worked on at a time. The scan reads the entry memory
//   once per entry, a read state then a compare state. An insert or a
//   delete then moves each later entry with one read and one write, and
//   an insert then writes the new entry. The single read port of the
//   memory, with registered read data, sets this pace.
// Reset:
//   rst_ni clears the entry count, so the table is empty; the entry memory
//   itself is not cleared and needs no sweep.
// Stall:
//   A finished result sits in the output register while out_stall_i is
//   high. The next request is still taken and worked on; it waits only if
//   its result is done before the previous one has been taken.
module priority_refcount_registry #(
  parameter int unsigned TableDepth = prr_pkg::TableDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [31:0] handler_id_i,
  input  logic signed [15:0] priority_req_i,
  input  logic        always_notify_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [4:0]  entries_used_o
);

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  prr_pkg::res_t   res;
  logic            res_take;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [IdxW-1:0] mem_raddr;
  prr_pkg::entry_t mem_wdata;
  prr_pkg::entry_t mem_rdata;

  logic            out_valid_q;
  logic [1:0]      status_q;
  logic [4:0]      used_q;

  prr_ctrl #(
    .Depth (TableDepth),
    .IdxW  (IdxW),
    .CntW  (CntW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .handler_id_i    (handler_id_i),
    .priority_req_i  (priority_req_i),
    .always_notify_i (always_notify_i),
    .res_o           (res),
    .res_take_i      (res_take),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata)
  );

  prr_mem #(
    .Depth (TableDepth),
    .IdxW  (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // load the result register when it is empty or being drained
  assign res_take = res.valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (res_take) begin
      status_q <= res.status;
      used_q   <= res.used;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign entries_used_o = used_q;

endmodule

/* hdl/prr_mem.sv */
// Entry store for the priority refcount registry.
// One write port, one read port with registered read data.
// Depends on prr_pkg.
module prr_mem #(
  parameter int unsigned Depth = prr_pkg::TableDepthDef,
  parameter int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  prr_pkg::entry_t wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output prr_pkg::entry_t rdata_o
);

  prr_pkg::entry_t mem [Depth];
  prr_pkg::entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/prr_ctrl.sv */
// Request sequencer for the priority refcount registry.
// Scans the entry store, updates counts, and shifts entries for insert/delete.
// Depends on prr_pkg; drives the ports of prr_mem.
module prr_ctrl #(
  parameter int unsigned Depth = prr_pkg::TableDepthDef,
  parameter int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1,
  parameter int unsigned CntW  = $clog2(Depth + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // request side
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            req_type_i,
  input  logic [31:0]     handler_id_i,
  input  logic [15:0]     priority_req_i,
  input  logic            always_notify_i,
  // result side
  output prr_pkg::res_t   res_o,
  input  logic            res_take_i,
  // entry store
  output logic            mem_we_o,
  output logic [IdxW-1:0] mem_waddr_o,
  output prr_pkg::entry_t mem_wdata_o,
  output logic [IdxW-1:0] mem_raddr_o,
  input  prr_pkg::entry_t mem_rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   total_q, total_d;
  logic [CntW-1:0]   idx_q, idx_d;     // scan index, later insert position
  logic [CntW-1:0]   k_q, k_d;         // shift cursor
  prr_pkg::status_e  status_q, status_d;
  logic              type_q, type_d;
  logic [31:0]       id_q, id_d;
  logic [15:0]       prio_q, prio_d;
  logic              notify_q, notify_d;

  logic              accept;
  logic              full;
  logic [CntW:0]     k_plus2;
  logic [CntW:0]     idx_plus1;
  logic [CntW-1:0]   k_minus1;
  logic [CntW-1:0]   k_plus1;
  prr_pkg::entry_t   upd;

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign full      = (total_q == CntW'(Depth));
  assign k_minus1  = k_q - CntW'(1);
  assign k_plus1   = k_q + CntW'(1);
  assign k_plus2   = {1'b0, k_q} + (CntW + 1)'(2);
  assign idx_plus1 = {1'b0, idx_q} + (CntW + 1)'(1);

  // next state and memory access
  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    idx_d       = idx_q;
    k_d         = k_q;
    status_d    = status_q;
    type_d      = type_q;
    id_d        = id_q;
    prio_d      = prio_q;
    notify_d    = notify_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q[IdxW-1:0];
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = idx_q[IdxW-1:0];
    upd         = mem_rdata_i;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          type_d   = req_type_i;
          id_d     = handler_id_i;
          prio_d   = priority_req_i;
          notify_d = always_notify_i;
          idx_d    = '0;
          status_d = prr_pkg::ST_OK;
          state_d  = S_SCAN_RD;
        end
      end

      S_SCAN_RD: begin
        if (idx_q == total_q) begin
          // scan ran off the end of the valid entries
          if (type_q == prr_pkg::ReqRemove) begin
            status_d = prr_pkg::ST_NOT_FOUND;
            state_d  = S_DONE;
          end else if (full) begin
            status_d = prr_pkg::ST_FULL;
            state_d  = S_DONE;
          end else begin
            k_d     = total_q;
            state_d = (total_q > idx_q) ? S_SHIFT_RD : S_INSERT;
          end
        end else begin
          mem_raddr_o = idx_q[IdxW-1:0];
          state_d     = S_SCAN_CHK;
        end
      end

      S_SCAN_CHK: begin
        if (mem_rdata_i.handler == id_q) begin
          if (type_q == prr_pkg::ReqAdd) begin
            // saturating increment
            if (mem_rdata_i.refs != prr_pkg::RefsMax) begin
              upd.refs = mem_rdata_i.refs + 16'd1;
            end
            mem_we_o    = 1'b1;
            mem_wdata_o = upd;
            state_d     = S_DONE;
          end else if (mem_rdata_i.refs > 16'd1) begin
            upd.refs    = mem_rdata_i.refs - 16'd1;
            mem_we_o    = 1'b1;
            mem_wdata_o = upd;
            state_d     = S_DONE;
          end else if (idx_plus1 < {1'b0, total_q}) begin
            // delete: pull later entries up one slot
            k_d     = idx_q;
            state_d = S_SHIFT_RD;
          end else begin
            total_d = total_q - CntW'(1);
            state_d = S_DONE;
          end
        end else if ((type_q == prr_pkg::ReqAdd) &&
                     ($signed(mem_rdata_i.prio) > $signed(prio_q))) begin
          // insert in front of the first higher priority entry
          if (full) begin
            status_d = prr_pkg::ST_FULL;
            state_d  = S_DONE;
          end else begin
            k_d     = total_q;
            state_d = S_SHIFT_RD;
          end
        end else begin
          idx_d   = idx_q + CntW'(1);
          state_d = S_SCAN_RD;
        end
      end

      S_SHIFT_RD: begin
        mem_raddr_o = (type_q == prr_pkg::ReqAdd) ? k_minus1[IdxW-1:0]
                                                  : k_plus1[IdxW-1:0];
        state_d     = S_SHIFT_WR;
      end

      S_SHIFT_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = k_q[IdxW-1:0];
        mem_wdata_o = mem_rdata_i;
        if (type_q == prr_pkg::ReqAdd) begin
          k_d     = k_minus1;
          state_d = (k_minus1 > idx_q) ? S_SHIFT_RD : S_INSERT;
        end else begin
          k_d = k_plus1;
          if (k_plus2 < {1'b0, total_q}) begin
            state_d = S_SHIFT_RD;
          end else begin
            total_d = total_q - CntW'(1);
            state_d = S_DONE;
          end
        end
      end

      S_INSERT: begin
        mem_we_o           = 1'b1;
        mem_waddr_o        = idx_q[IdxW-1:0];
        mem_wdata_o.handler = id_q;
        mem_wdata_o.prio    = prio_q;
        mem_wdata_o.refs    = 16'd1;
        mem_wdata_o.notify  = notify_q;
        total_d            = total_q + CntW'(1);
        state_d            = S_DONE;
      end

      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and request registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      total_q  <= '0;
      status_q <= prr_pkg::ST_OK;
      idx_q    <= '0;
      k_q      <= '0;
      type_q   <= prr_pkg::ReqAdd;
      id_q     <= '0;
      prio_q   <= '0;
      notify_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      total_q  <= total_d;
      status_q <= status_d;
      idx_q    <= idx_d;
      k_q      <= k_d;
      type_q   <= type_d;
      id_q     <= id_d;
      prio_q   <= prio_d;
      notify_q <= notify_d;
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign res_o.valid  = (state_q == S_DONE);
  assign res_o.status = status_q;
  assign res_o.used   = 5'(total_q);

endmodule
